FILE: sv/vtpg_pkg.sv
// Shared types, constants and color tables for the video test pattern generator.
`default_nettype none

package vtpg_pkg;

    // Field and register widths
    localparam int COORD_W  = 12;
    localparam int DIM_W    = 13;
    localparam int COLOR_W  = 8;
    localparam int PHASE_W  = 8;
    localparam int MODE_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    // Frame size limits
    localparam int MIN_WIDTH  = 8;
    localparam int MAX_WIDTH  = 4096;
    localparam int MIN_HEIGHT = 1;
    localparam int MAX_HEIGHT = 4096;

    // Register reset values
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int RESET_LEVEL  = 128;

    // Gradient: phase and colors run modulo 255
    localparam int PHASE_MOD = 255;
    localparam int GREEN_OFS = 85;
    localparam int BLUE_OFS  = 170;

    // Color bars
    localparam int BAR_COUNT = 8;
    localparam int BAR_SEL_W = $clog2(BAR_COUNT);
    localparam int BAR_W_W   = DIM_W - BAR_SEL_W;

    // Checkerboard: square edge is 2**CHECKER_LOG2 pixels
    localparam int CHECKER_LOG2 = 5;
    localparam int CHECK_HI = 255;
    localparam int CHECK_LO = 64;

    // Pulse mode: striped block around the frame center
    localparam int BLOCK_HALF_W = 60;
    localparam int BLOCK_HALF_H = 20;
    localparam int STRIPE_W     = 30;
    localparam int STRIPE_PITCH = 10;
    localparam int STRIPE_H     = 5;
    localparam int FULL_LEVEL   = 255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2,
        CFG_LEVEL  = 2'd3
    } cfg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_GRADIENT = 3'd0,
        MODE_BARS     = 3'd1,
        MODE_CHECKER  = 3'd2,
        MODE_BLACK    = 3'd3,
        MODE_PULSE    = 3'd4
    } mode_t;

    // Active configuration, frame size already clamped to its legal range
    typedef struct packed {
        mode_t              mode;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [COLOR_W-1:0] level;
    } cfg_t;

    // One scan position on its way to the color stage
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PHASE_W-1:0] phase;
        logic               lend;
        logic               fend;
    } scan_item_t;

    // Bar colors, packed as {red, green, blue}
    function automatic logic [3*COLOR_W-1:0] bar_rgb(input logic [BAR_SEL_W-1:0] bar);
        logic [3*COLOR_W-1:0] rgb;
        case (bar)
            3'd0:    rgb = 24'hFFFFFF;
            3'd1:    rgb = 24'hFFFF00;
            3'd2:    rgb = 24'h00FFFF;
            3'd3:    rgb = 24'h00FF00;
            3'd4:    rgb = 24'hFF00FF;
            3'd5:    rgb = 24'hFF0000;
            3'd6:    rgb = 24'h0000FF;
            default: rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

endpackage

`default_nettype wire

FILE: sv/vtpg_cfg.sv
// Configuration registers of the pattern generator, with frame size clamping.
`default_nettype none

module vtpg_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [vtpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [vtpg_pkg::CFG_DATA_W-1:0] cfg_data,
    output vtpg_pkg::cfg_t                       cfg
);

    vtpg_pkg::mode_t                   mode_reg, mode_next;
    logic [vtpg_pkg::DIM_W-1:0]        width_reg, width_next;
    logic [vtpg_pkg::DIM_W-1:0]        height_reg, height_next;
    logic [vtpg_pkg::COLOR_W-1:0]      level_reg, level_next;

    // Register write decode
    always_comb
    begin
        mode_next   = mode_reg;
        width_next  = width_reg;
        height_next = height_reg;
        level_next  = level_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                vtpg_pkg::CFG_MODE:   mode_next   = vtpg_pkg::mode_t'(cfg_data[vtpg_pkg::MODE_W-1:0]);
                vtpg_pkg::CFG_WIDTH:  width_next  = cfg_data[vtpg_pkg::DIM_W-1:0];
                vtpg_pkg::CFG_HEIGHT: height_next = cfg_data[vtpg_pkg::DIM_W-1:0];
                vtpg_pkg::CFG_LEVEL:  level_next  = cfg_data[vtpg_pkg::COLOR_W-1:0];
                default:              mode_next   = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= vtpg_pkg::MODE_GRADIENT;
            width_reg  <= vtpg_pkg::DIM_W'(vtpg_pkg::RESET_WIDTH);
            height_reg <= vtpg_pkg::DIM_W'(vtpg_pkg::RESET_HEIGHT);
            level_reg  <= vtpg_pkg::COLOR_W'(vtpg_pkg::RESET_LEVEL);
        end
        else
        begin
            mode_reg   <= mode_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            level_reg  <= level_next;
        end
    end

    // Clamp frame size into the supported range
    always_comb
    begin
        cfg.mode  = mode_reg;
        cfg.level = level_reg;
        if (width_reg < vtpg_pkg::DIM_W'(vtpg_pkg::MIN_WIDTH))
            cfg.width = vtpg_pkg::DIM_W'(vtpg_pkg::MIN_WIDTH);
        else if (width_reg > vtpg_pkg::DIM_W'(vtpg_pkg::MAX_WIDTH))
            cfg.width = vtpg_pkg::DIM_W'(vtpg_pkg::MAX_WIDTH);
        else
            cfg.width = width_reg;
        if (height_reg < vtpg_pkg::DIM_W'(vtpg_pkg::MIN_HEIGHT))
            cfg.height = vtpg_pkg::DIM_W'(vtpg_pkg::MIN_HEIGHT);
        else if (height_reg > vtpg_pkg::DIM_W'(vtpg_pkg::MAX_HEIGHT))
            cfg.height = vtpg_pkg::DIM_W'(vtpg_pkg::MAX_HEIGHT);
        else
            cfg.height = height_reg;
    end

endmodule

`default_nettype wire

FILE: sv/vtpg_scan.sv
// Raster scan counters and the input stage register of the pattern generator.
`default_nettype none

module vtpg_scan (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire vtpg_pkg::cfg_t       cfg,
    input  wire logic                 accept,
    input  wire logic                 restart,
    input  wire logic                 down_ready,
    output logic                      item_valid,
    output vtpg_pkg::scan_item_t      item
);

    logic [vtpg_pkg::COORD_W-1:0] col_reg, col_next;
    logic [vtpg_pkg::COORD_W-1:0] row_reg, row_next;
    logic [vtpg_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                         valid_reg, valid_next;
    vtpg_pkg::scan_item_t         item_reg, item_next;

    logic [vtpg_pkg::COORD_W-1:0] x0, y0;
    logic                         lend, fend;

    // Position of the pixel emitted for this request
    always_comb
    begin
        if (restart || ({1'b0, col_reg} >= cfg.width))
            x0 = '0;
        else
            x0 = col_reg;
        if (restart || ({1'b0, row_reg} >= cfg.height))
            y0 = '0;
        else
            y0 = row_reg;
        lend = ({1'b0, x0} == cfg.width - vtpg_pkg::DIM_W'(1));
        fend = lend && ({1'b0, y0} == cfg.height - vtpg_pkg::DIM_W'(1));
    end

    // Scan advance in raster order
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        if (accept)
        begin
            if (lend)
            begin
                col_next = '0;
                if (fend)
                begin
                    row_next = '0;
                    if (phase_reg == vtpg_pkg::PHASE_W'(vtpg_pkg::PHASE_MOD - 1))
                        phase_next = '0;
                    else
                        phase_next = phase_reg + vtpg_pkg::PHASE_W'(1);
                end
                else
                begin
                    row_next = y0 + vtpg_pkg::COORD_W'(1);
                end
            end
            else
            begin
                col_next = x0 + vtpg_pkg::COORD_W'(1);
                row_next = y0;
            end
        end
    end

    // Stage register
    always_comb
    begin
        valid_next = accept || (valid_reg && !down_ready);
        item_next  = item_reg;
        if (accept)
        begin
            item_next.x     = x0;
            item_next.y     = y0;
            item_next.phase = phase_reg;
            item_next.lend  = lend;
            item_next.fend  = fend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            phase_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

`ifndef NO_ASSERTIONS
    // Frame phase stays below its modulus
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg < vtpg_pkg::PHASE_W'(vtpg_pkg::PHASE_MOD))
        else $error("frame phase out of range");

    // A staged pixel lies inside the frame
    a_item_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (({1'b0, item_reg.x} < cfg.width) && ({1'b0, item_reg.y} < cfg.height)))
        else $error("staged pixel outside the frame");

    // Frame end is always also a line end
    a_fend_lend: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && item_reg.fend |-> item_reg.lend)
        else $error("frame end without line end");

    // A line end sends the scan back to column zero
    a_line_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && lend |=> col_reg == '0)
        else $error("scan did not wrap after line end");
`endif

endmodule

`default_nettype wire

FILE: sv/vtpg_color.sv
// Pattern color logic and output register of the pattern generator.
`default_nettype none

module vtpg_color (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire vtpg_pkg::cfg_t                cfg,
    input  wire logic                          item_valid,
    input  wire vtpg_pkg::scan_item_t          item,
    input  wire logic                          out_stall,
    output logic                               ready,
    output logic                               out_valid,
    output logic [vtpg_pkg::COLOR_W-1:0]       red,
    output logic [vtpg_pkg::COLOR_W-1:0]       green,
    output logic [vtpg_pkg::COLOR_W-1:0]       blue,
    output logic [vtpg_pkg::COORD_W-1:0]       column,
    output logic [vtpg_pkg::COORD_W-1:0]       row,
    output logic                               line_end,
    output logic                               frame_end
);

    localparam int SUM_W = vtpg_pkg::COORD_W + 2;

    logic                          valid_reg, valid_next;
    logic [vtpg_pkg::COLOR_W-1:0]  red_reg, green_reg, blue_reg;
    logic [vtpg_pkg::COLOR_W-1:0]  red_next, green_next, blue_next;
    logic [vtpg_pkg::COORD_W-1:0]  column_reg, row_reg;
    logic                          lend_reg, fend_reg;
    logic                          load;

    // Gradient
    logic [SUM_W-1:0]              grad_sum;
    logic [vtpg_pkg::COLOR_W:0]    grad_fold, grad_g, grad_b;
    logic [vtpg_pkg::COLOR_W-1:0]  grad_r;

    // Bars
    logic [vtpg_pkg::BAR_W_W-1:0]  bar_w;
    logic [vtpg_pkg::BAR_COUNT-1:1] bar_ge;
    logic [vtpg_pkg::BAR_SEL_W-1:0] bar_sel;
    logic [3*vtpg_pkg::COLOR_W-1:0] bar_color;

    // Checker
    logic [vtpg_pkg::COLOR_W-1:0]  check_v;

    // Pulse block
    logic [vtpg_pkg::DIM_W-1:0]    cx, cy;
    logic [SUM_W:0]                dx, dy;
    logic                          in_block, stripe_x, stripe_y;

    // Gradient: (x + y + phase) mod 255 by folding the high byte
    always_comb
    begin
        grad_sum  = SUM_W'(item.x) + SUM_W'(item.y) + SUM_W'(item.phase);
        grad_fold = (vtpg_pkg::COLOR_W+1)'(grad_sum[vtpg_pkg::COLOR_W-1:0])
                  + (vtpg_pkg::COLOR_W+1)'(grad_sum[SUM_W-1:vtpg_pkg::COLOR_W]);
        if (grad_fold >= (vtpg_pkg::COLOR_W+1)'(vtpg_pkg::PHASE_MOD))
            grad_r = vtpg_pkg::COLOR_W'(grad_fold - (vtpg_pkg::COLOR_W+1)'(vtpg_pkg::PHASE_MOD));
        else
            grad_r = vtpg_pkg::COLOR_W'(grad_fold);
        grad_g = (vtpg_pkg::COLOR_W+1)'(grad_r) + (vtpg_pkg::COLOR_W+1)'(vtpg_pkg::GREEN_OFS);
        if (grad_g >= (vtpg_pkg::COLOR_W+1)'(vtpg_pkg::PHASE_MOD))
            grad_g = grad_g - (vtpg_pkg::COLOR_W+1)'(vtpg_pkg::PHASE_MOD);
        grad_b = (vtpg_pkg::COLOR_W+1)'(grad_r) + (vtpg_pkg::COLOR_W+1)'(vtpg_pkg::BLUE_OFS);
        if (grad_b >= (vtpg_pkg::COLOR_W+1)'(vtpg_pkg::PHASE_MOD))
            grad_b = grad_b - (vtpg_pkg::COLOR_W+1)'(vtpg_pkg::PHASE_MOD);
    end

    // Bars: count the bar boundaries at or left of x; last bar takes the rest
    always_comb
    begin
        bar_w   = vtpg_pkg::BAR_W_W'(cfg.width >> vtpg_pkg::BAR_SEL_W);
        bar_sel = '0;
        for (int k = 1; k < vtpg_pkg::BAR_COUNT; k++)
        begin
            bar_ge[k] = ({1'b0, item.x} >= vtpg_pkg::DIM_W'(bar_w * k));
            bar_sel   = bar_sel + vtpg_pkg::BAR_SEL_W'(bar_ge[k]);
        end
        bar_color = vtpg_pkg::bar_rgb(bar_sel);
    end

    // Checker: parity of the square indexes
    always_comb
    begin
        if (item.x[vtpg_pkg::CHECKER_LOG2] ^ item.y[vtpg_pkg::CHECKER_LOG2])
            check_v = vtpg_pkg::COLOR_W'(vtpg_pkg::CHECK_LO);
        else
            check_v = vtpg_pkg::COLOR_W'(vtpg_pkg::CHECK_HI);
    end

    // Pulse block: offsets from the block's top-left corner, negative means outside
    always_comb
    begin
        cx = cfg.width >> 1;
        cy = cfg.height >> 1;
        dx = (SUM_W+1)'(item.x) + (SUM_W+1)'(vtpg_pkg::BLOCK_HALF_W) - (SUM_W+1)'(cx);
        dy = (SUM_W+1)'(item.y) + (SUM_W+1)'(vtpg_pkg::BLOCK_HALF_H) - (SUM_W+1)'(cy);
        in_block = !dx[SUM_W] && (dx < (SUM_W+1)'(2 * vtpg_pkg::BLOCK_HALF_W))
                && !dy[SUM_W] && (dy < (SUM_W+1)'(2 * vtpg_pkg::BLOCK_HALF_H));
        stripe_x = (dx < (SUM_W+1)'(vtpg_pkg::STRIPE_W))
                || ((dx >= (SUM_W+1)'(2 * vtpg_pkg::STRIPE_W))
                    && (dx < (SUM_W+1)'(3 * vtpg_pkg::STRIPE_W)));
        stripe_y = 1'b0;
        for (int k = 0; k < (2 * vtpg_pkg::BLOCK_HALF_H) / vtpg_pkg::STRIPE_PITCH; k++)
        begin
            if ((dy >= (SUM_W+1)'(k * vtpg_pkg::STRIPE_PITCH))
                && (dy < (SUM_W+1)'(k * vtpg_pkg::STRIPE_PITCH + vtpg_pkg::STRIPE_H)))
                stripe_y = 1'b1;
        end
    end

    // Pattern select
    always_comb
    begin
        case (cfg.mode)
            vtpg_pkg::MODE_BARS:
            begin
                red_next   = bar_color[3*vtpg_pkg::COLOR_W-1:2*vtpg_pkg::COLOR_W];
                green_next = bar_color[2*vtpg_pkg::COLOR_W-1:vtpg_pkg::COLOR_W];
                blue_next  = bar_color[vtpg_pkg::COLOR_W-1:0];
            end
            vtpg_pkg::MODE_CHECKER:
            begin
                red_next   = check_v;
                green_next = check_v;
                blue_next  = check_v;
            end
            vtpg_pkg::MODE_BLACK:
            begin
                red_next   = '0;
                green_next = '0;
                blue_next  = '0;
            end
            vtpg_pkg::MODE_PULSE:
            begin
                if (in_block && stripe_x && stripe_y)
                begin
                    red_next   = vtpg_pkg::COLOR_W'(vtpg_pkg::FULL_LEVEL);
                    green_next = vtpg_pkg::COLOR_W'(vtpg_pkg::FULL_LEVEL);
                    blue_next  = vtpg_pkg::COLOR_W'(vtpg_pkg::FULL_LEVEL);
                end
                else
                begin
                    red_next   = cfg.level;
                    green_next = '0;
                    blue_next  = '0;
                end
            end
            default:
            begin
                red_next   = grad_r;
                green_next = vtpg_pkg::COLOR_W'(grad_g);
                blue_next  = vtpg_pkg::COLOR_W'(grad_b);
            end
        endcase
    end

    // Output register handshake
    assign ready      = !valid_reg || !out_stall;
    assign load       = item_valid && ready;
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            column_reg <= item.x;
            row_reg    <= item.y;
            lend_reg   <= item.lend;
            fend_reg   <= item.fend;
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign column    = column_reg;
    assign row       = row_reg;
    assign line_end  = lend_reg;
    assign frame_end = fend_reg;

endmodule

`default_nettype wire

FILE: sv/video_test_pattern_generator.sv
// Top level of the video test pattern generator.
//
// Each accepted request emits one RGB pixel at the current raster position and
// advances the scan; one request is taken per clock while in_stall is low, and
// results pass from the scan stage register through the color logic into the
// output register. The throughput of one pixel per clock is set by the scan
// counter update, which settles the next position in the same cycle a request
// is taken. A stall on the output holds the result register and, once the
// scan stage is also full, stalls the input. Modes: 0 moving gradient, 1 eight
// color bars, 2 checkerboard, 3 black, 4 red pulse level with a white striped
// block in the center; unused mode codes show the gradient. Frame size is
// clamped to 8..4096 pixels by 1..4096 lines. Configuration must be written
// only while no request is in flight; the block itself does not enforce this.
`default_nettype none

module video_test_pattern_generator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [vtpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [vtpg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            restart,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [vtpg_pkg::COLOR_W-1:0]         red,
    output logic [vtpg_pkg::COLOR_W-1:0]         green,
    output logic [vtpg_pkg::COLOR_W-1:0]         blue,
    output logic [vtpg_pkg::COORD_W-1:0]         column,
    output logic [vtpg_pkg::COORD_W-1:0]         row,
    output logic                                 line_end,
    output logic                                 frame_end
);

    vtpg_pkg::cfg_t       cfg;
    vtpg_pkg::scan_item_t item;
    logic                 item_valid;
    logic                 color_ready;
    logic                 accept;

    // Input request taken when the scan stage is free or moving on
    assign in_stall = item_valid && !color_ready;
    assign accept   = in_valid && !in_stall;

    vtpg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vtpg_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .accept     (accept),
        .restart    (restart),
        .down_ready (color_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    vtpg_color u_color (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .out_stall  (out_stall),
        .ready      (color_ready),
        .out_valid  (out_valid),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .column     (column),
        .row        (row),
        .line_end   (line_end),
        .frame_end  (frame_end)
    );

endmodule

`default_nettype wire
